### hdl/kbt_pkg.sv
// ----------------------------------------------------------------------------
// kbt_pkg
// shared sizes, table entry type and outcome codes for the best-time table
// ----------------------------------------------------------------------------
package kbt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 24;
  localparam int TIME_W      = 24;
  localparam int RANK_W      = 5;

  typedef struct packed {
    logic [KEY_W-1:0]  driver;
    logic [TIME_W-1:0] time_ms;
  } entry_t;

  // result of one pass through the shared compare unit
  typedef struct packed {
    logic key_eq;
    logic t_less;
  } cmp_res_t;

  typedef enum logic [1:0] {
    OUT_NEW      = 2'd0,
    OUT_IMPROVED = 2'd1,
    OUT_KEPT     = 2'd2,
    OUT_DROPPED  = 2'd3
  } outcome_t;

endpackage

### hdl/keyed_best_time_sorted_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_best_time_sorted_table_unit
// keyed best-time table kept sorted by time, listed in full after every word
// ----------------------------------------------------------------------------
// Each input word brings a driver code and a lap time. The block keeps at most
// one entry per code, sorted ascending by time (new entries go after equal
// times), and after every input word lists the whole table best-first, one
// output word per entry, all carrying the same outcome code; last_entry marks
// the final word. The block takes one input word at a time and holds in_stall
// high until the listing has been fully taken. Each word runs through a key
// search over the stored entries, a decision, a shift and write of the entries
// moved by the insert when the table changes, and the listing of every entry.
// The search and the shift walk the single read port of the entry memory one
// entry per cycle, and the listing walks it one entry at a time, held while
// out_stall is high; one compare unit checks each entry once.
// ----------------------------------------------------------------------------
module keyed_best_time_sorted_table_unit
  import kbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KEY_W-1:0]  driver_code,
  input  logic [TIME_W-1:0] lap_time_ms,
  // output channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [RANK_W-1:0] rank,
  output logic [KEY_W-1:0]  entry_driver,
  output logic [TIME_W-1:0] entry_time_ms,
  output logic [1:0]        outcome,
  output logic              last_entry
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_INSERT,
    ST_LIST_RD,
    ST_LIST_LOAD,
    ST_LIST_OUT
  } state_t;

  state_t            state;

  // captured input word
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] time_r;

  // table occupancy
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  used_dec;

  // key search bookkeeping
  logic [CNT_W-1:0]  rd_idx;
  logic              cmp_vld;
  logic [CNT_W-1:0]  cmp_idx;
  logic              found;
  logic [CNT_W-1:0]  fidx;
  logic              less_old;
  logic              pos_set;
  logic [CNT_W-1:0]  pos;

  // shift bookkeeping
  logic [CNT_W-1:0]  sh_rd;
  logic [CNT_W-1:0]  sh_rd_dec;
  logic              wr_vld;
  logic [IDX_W-1:0]  wr_idx;

  // listing
  logic [CNT_W-1:0]  lidx;
  logic [CNT_W-1:0]  lidx_inc;
  outcome_t          outc;

  // memory ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;
  cmp_res_t          cmp;

  assign used_dec  = used - 1'b1;
  assign sh_rd_dec = sh_rd - 1'b1;
  assign lidx_inc  = lidx + 1'b1;

  // busy from accept until the last listing word is taken
  assign in_stall = (state != ST_IDLE);
  assign outcome  = outc;

  kbt_table_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kbt_cmp_unit u_cmp (
    .ent     (ram_rdata),
    .key     (key_r),
    .time_ms (time_r),
    .res     (cmp)
  );

  // read address follows the walk of the current phase
  always_comb begin
    case (state)
      ST_SCAN:     ram_raddr = rd_idx[IDX_W-1:0];
      ST_SHIFT:    ram_raddr = sh_rd_dec[IDX_W-1:0];
      ST_LIST_OUT: ram_raddr = lidx_inc[IDX_W-1:0];   // prefetch next rank
      default:     ram_raddr = '0;
    endcase
  end

  // shift moves entry i-1 up to i; the insert then drops the new word at pos
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_idx;
    ram_wdata = ram_rdata;
    if (state == ST_SHIFT && wr_vld) begin
      ram_we = 1'b1;
    end else if (state == ST_INSERT) begin
      ram_we            = 1'b1;
      ram_waddr         = pos[IDX_W-1:0];
      ram_wdata.driver  = key_r;
      ram_wdata.time_ms = time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
      cmp_vld   <= 1'b0;
      wr_vld    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            key_r    <= driver_code;
            time_r   <= lap_time_ms;
            rd_idx   <= '0;
            cmp_vld  <= 1'b0;
            found    <= 1'b0;
            less_old <= 1'b0;
            pos_set  <= 1'b0;
            pos      <= used;     // append point unless a larger time shows up
            if (used == '0) begin
              state <= ST_DECIDE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end

        // one read issued and one entry compared per cycle
        ST_SCAN: begin
          if (rd_idx != used) begin
            rd_idx  <= rd_idx + 1'b1;
            cmp_vld <= 1'b1;
            cmp_idx <= rd_idx;
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld) begin
            if (cmp.key_eq) begin
              found    <= 1'b1;
              fidx     <= cmp_idx;
              less_old <= cmp.t_less;
            end
            // first entry with a strictly larger time: new word goes there
            if (cmp.t_less && !pos_set) begin
              pos_set <= 1'b1;
              pos     <= cmp_idx;
            end
            if (cmp_idx == used_dec) begin
              state <= ST_DECIDE;
            end
          end
        end

        // the removed, evicted or first free slot is the top of the shift window
        ST_DECIDE: begin
          wr_vld <= 1'b0;
          if (found) begin
            if (less_old) begin
              outc  <= OUT_IMPROVED;
              sh_rd <= fidx;
              state <= ST_SHIFT;
            end else begin
              outc  <= OUT_KEPT;
              state <= ST_LIST_RD;
            end
          end else if (used != CNT_W'(TABLE_DEPTH)) begin
            outc  <= OUT_NEW;
            sh_rd <= used;
            used  <= used + 1'b1;
            state <= ST_SHIFT;
          end else if (pos_set) begin
            // full table, better than the worst time: worst entry falls off
            outc  <= OUT_NEW;
            sh_rd <= CNT_W'(TABLE_DEPTH - 1);
            state <= ST_SHIFT;
          end else begin
            outc  <= OUT_DROPPED;
            state <= ST_LIST_RD;
          end
        end

        ST_SHIFT: begin
          if (sh_rd != pos) begin
            sh_rd  <= sh_rd_dec;
            wr_vld <= 1'b1;
            wr_idx <= sh_rd[IDX_W-1:0];
          end else begin
            wr_vld <= 1'b0;
            if (!wr_vld) begin
              state <= ST_INSERT;
            end
          end
        end

        ST_INSERT: begin
          state <= ST_LIST_RD;
        end

        ST_LIST_RD: begin
          lidx  <= '0;
          state <= ST_LIST_LOAD;
        end

        ST_LIST_LOAD: begin
          out_valid     <= 1'b1;
          rank          <= RANK_W'(lidx_inc);
          entry_driver  <= ram_rdata.driver;
          entry_time_ms <= ram_rdata.time_ms;
          last_entry    <= (lidx_inc == used);
          state         <= ST_LIST_OUT;
        end

        ST_LIST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_entry) begin
              state <= ST_IDLE;
            end else begin
              lidx  <= lidx_inc;
              state <= ST_LIST_LOAD;
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/kbt_table_ram.sv
// ----------------------------------------------------------------------------
// kbt_table_ram
// entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module kbt_table_ram
  import kbt_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/kbt_cmp_unit.sv
// ----------------------------------------------------------------------------
// kbt_cmp_unit
// shared compare unit: key match and strict time compare against one entry
// ----------------------------------------------------------------------------
module kbt_cmp_unit
  import kbt_pkg::*;
(
  input  entry_t            ent,
  input  logic [KEY_W-1:0]  key,
  input  logic [TIME_W-1:0] time_ms,
  output cmp_res_t          res
);

  always_comb begin
    res.key_eq = (ent.driver == key);
    res.t_less = (time_ms < ent.time_ms);
  end

endmodule

### hdl/kbt_checker.sv
// ----------------------------------------------------------------------------
// kbt_checker
// port-level checks of the best-time table handshakes and listing framing
// ----------------------------------------------------------------------------
module kbt_checker
  import kbt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [KEY_W-1:0]  driver_code,
  input logic [TIME_W-1:0] lap_time_ms,
  input logic              out_valid,
  input logic              out_stall,
  input logic [RANK_W-1:0] rank,
  input logic [KEY_W-1:0]  entry_driver,
  input logic [TIME_W-1:0] entry_time_ms,
  input logic [1:0]        outcome,
  input logic              last_entry
);

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(driver_code) && $stable(lap_time_ms))
    else $error("stalled input word changed");

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rank) && $stable(entry_driver)
      && $stable(entry_time_ms) && $stable(outcome) && $stable(last_entry))
    else $error("stalled output word changed");

  // no new input word while a listing is shown
  a_busy_listing: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken during listing");

  // an accepted word keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after accept");

  // the final word of a listing closes it
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_entry |=> !out_valid)
    else $error("output word after last entry");

endmodule

bind keyed_best_time_sorted_table_unit kbt_checker u_kbt_checker (.*);
